### rtl/dgcp_pkg.sv
// Shared constants and types for the decimal gain command parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dgcp_pkg;

   localparam int DigitsPerField = 4;
   localparam int NumFields      = 4;
   localparam int FrameLen       = 1 + NumFields * DigitsPerField;

   localparam int ByteW  = 8;
   localparam int PosW   = 5;
   localparam int DigitW = 2;
   localparam int FieldW = 2;
   localparam int ParamW = 14;
   localparam int DvW    = 4;

   localparam logic [ByteW-1:0] CharStop = 8'h73;
   localparam logic [ByteW-1:0] CharRun  = 8'h6B;
   localparam logic [ByteW-1:0] CharZero = 8'h30;
   localparam logic [ByteW-1:0] CharNine = 8'h39;

   localparam logic KindStop  = 1'b0;
   localparam logic KindFrame = 1'b1;

   typedef struct packed {
      logic              kind;
      logic              run_mode;
      logic [ParamW-1:0] gain_p;
      logic [ParamW-1:0] gain_i;
      logic [ParamW-1:0] gain_d;
      logic [ParamW-1:0] reference;
      logic              bad_digit;
   } rsp_type;

endpackage

### rtl/decimal_gain_command_parser.sv
// Decimal gain command parser top level: input register, parser, result register.
// Path: input register, then parser, then result register, which drives rsp_valid.
// Throughput: one byte per cycle while rsp_stall does not block the result register.
// Reset: synchronous, active high; clears position, mode, flags and parameters to 0.
// Depends on dgcp_pkg, dgcp_parse and dgcp_outreg.
`timescale 1ns / 1ps

module decimal_gain_command_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dgcp_pkg::ByteW-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic                          rsp_run_mode,
   output logic [dgcp_pkg::ParamW-1:0]   rsp_gain_p,
   output logic [dgcp_pkg::ParamW-1:0]   rsp_gain_i,
   output logic [dgcp_pkg::ParamW-1:0]   rsp_gain_d,
   output logic [dgcp_pkg::ParamW-1:0]   rsp_reference,
   output logic                          rsp_bad_digit
);

   logic                        in_valid_ff, in_valid_in;
   logic [dgcp_pkg::ByteW-1:0]  in_byte_ff;
   logic                        accept;
   logic                        go;
   logic                        out_free;
   logic                        res_valid;
   dgcp_pkg::rsp_type           res;
   dgcp_pkg::rsp_type           rsp;

   assign go          = in_valid_ff & out_free;
   assign req_stall   = in_valid_ff & ~out_free;
   assign accept      = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   dgcp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   dgcp_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (go & res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_kind      = rsp.kind;
   assign rsp_run_mode  = rsp.run_mode;
   assign rsp_gain_p    = rsp.gain_p;
   assign rsp_gain_i    = rsp.gain_i;
   assign rsp_gain_d    = rsp.gain_d;
   assign rsp_reference = rsp.reference;
   assign rsp_bad_digit = rsp.bad_digit;

   a_stop_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dgcp_pkg::KindStop) |-> !rsp_bad_digit && !rsp_run_mode)
      else $error("stop item with run mode or bad digit set");

   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("pending input byte lost while result register blocked");

   a_result_lands : assert property (@(posedge clock) disable iff (reset)
      go && res_valid |=> rsp_valid)
      else $error("parser result not captured in result register");

   a_param_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain_p <= dgcp_pkg::ParamW'(9999)
                 && rsp_reference <= dgcp_pkg::ParamW'(9999))
      else $error("parameter out of decimal range");

endmodule

### rtl/dgcp_parse.sv
// Frame parser: byte position, digit accumulate, pending fields and stored parameters.
// Depends on dgcp_pkg.
`timescale 1ns / 1ps

module dgcp_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [dgcp_pkg::ByteW-1:0]   rx_byte,
   output logic                         res_valid,
   output dgcp_pkg::rsp_type            res
);

   localparam logic [dgcp_pkg::PosW-1:0] Dpf =
      dgcp_pkg::PosW'(dgcp_pkg::DigitsPerField);
   localparam logic [dgcp_pkg::PosW-1:0] FrameEnd =
      dgcp_pkg::PosW'(dgcp_pkg::FrameLen);
   localparam logic [dgcp_pkg::DigitW-1:0] LastDigit =
      dgcp_pkg::DigitW'(dgcp_pkg::DigitsPerField - 1);
   localparam logic [dgcp_pkg::FieldW-1:0] LastField =
      dgcp_pkg::FieldW'(dgcp_pkg::NumFields - 1);

   logic [dgcp_pkg::PosW-1:0]   pos_ff, pos_in;
   logic [dgcp_pkg::ByteW-1:0]  cmd_ff, cmd_in;
   logic [dgcp_pkg::ParamW-1:0] acc_ff, acc_in;
   logic                        err_ff, err_in;
   logic                        run_ff, run_in;
   logic [dgcp_pkg::ParamW-1:0] pend_ff [dgcp_pkg::NumFields-1];
   logic [dgcp_pkg::ParamW-1:0] par_ff  [dgcp_pkg::NumFields];
   logic [dgcp_pkg::ParamW-1:0] par_in  [dgcp_pkg::NumFields];

   logic                          start;
   logic [dgcp_pkg::PosW-1:0]     rel;
   logic [dgcp_pkg::FieldW-1:0]   field_idx;
   logic [dgcp_pkg::DigitW-1:0]   digit_idx;
   logic                          is_digit;
   logic [dgcp_pkg::DvW-1:0]      dv;
   logic [dgcp_pkg::ParamW-1:0]   acc_base;
   logic [dgcp_pkg::ParamW+3:0]   acc_sum;
   logic [dgcp_pkg::ParamW-1:0]   acc_new;
   logic                          err_new;
   logic                          pend_we;

   always_comb begin
      start     = (pos_ff == '0) || (pos_ff >= FrameEnd);
      rel       = pos_ff - dgcp_pkg::PosW'(1);
      field_idx = dgcp_pkg::FieldW'(rel / Dpf);
      digit_idx = dgcp_pkg::DigitW'(rel % Dpf);
      is_digit  = rx_byte inside {[dgcp_pkg::CharZero : dgcp_pkg::CharNine]};
      dv        = is_digit ? dgcp_pkg::DvW'(rx_byte - dgcp_pkg::CharZero) : '0;
      acc_base  = (digit_idx == '0) ? '0 : acc_ff;
      acc_sum   = (dgcp_pkg::ParamW+4)'(acc_base) * (dgcp_pkg::ParamW+4)'(10)
                + (dgcp_pkg::ParamW+4)'(dv);
      acc_new   = acc_sum[dgcp_pkg::ParamW-1:0];
      err_new   = err_ff | ~is_digit;
   end

   always_comb begin
      pos_in    = pos_ff;
      cmd_in    = cmd_ff;
      acc_in    = acc_ff;
      err_in    = err_ff;
      run_in    = run_ff;
      par_in    = par_ff;
      pend_we   = 1'b0;
      res_valid = 1'b0;
      res.kind  = dgcp_pkg::KindFrame;
      res.bad_digit = 1'b0;
      if (start) begin
         pos_in = '0;
         if (rx_byte == dgcp_pkg::CharStop) begin
            run_in    = 1'b0;
            res_valid = 1'b1;
            res.kind  = dgcp_pkg::KindStop;
         end else begin
            cmd_in = rx_byte;
            acc_in = '0;
            err_in = 1'b0;
            pos_in = dgcp_pkg::PosW'(1);
         end
      end else begin
         acc_in = acc_new;
         err_in = err_new;
         pos_in = pos_ff + dgcp_pkg::PosW'(1);
         if (digit_idx == LastDigit) begin
            if (field_idx != LastField) begin
               pend_we = 1'b1;
            end else begin
               if (cmd_ff == dgcp_pkg::CharRun) begin
                  run_in = 1'b1;
               end
               if (!err_new) begin
                  for (int i = 0; i < dgcp_pkg::NumFields - 1; i++) begin
                     par_in[i] = pend_ff[i];
                  end
                  par_in[dgcp_pkg::NumFields-1] = acc_new;
               end
               res_valid     = 1'b1;
               res.bad_digit = err_new;
               pos_in = '0;
               acc_in = '0;
               err_in = 1'b0;
            end
         end
      end
      res.run_mode  = run_in;
      res.gain_p    = par_in[0];
      res.gain_i    = par_in[1];
      res.gain_d    = par_in[2];
      res.reference = par_in[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         acc_ff <= '0;
         err_ff <= 1'b0;
         run_ff <= 1'b0;
         for (int i = 0; i < dgcp_pkg::NumFields; i++) begin
            par_ff[i] <= '0;
         end
      end else if (go) begin
         pos_ff <= pos_in;
         acc_ff <= acc_in;
         err_ff <= err_in;
         run_ff <= run_in;
         par_ff <= par_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         cmd_ff <= cmd_in;
         if (pend_we) begin
            pend_ff[field_idx] <= acc_new;
         end
      end
   end

endmodule

### rtl/dgcp_outreg.sv
// Result register: holds one result item until the consumer takes it.
// Depends on dgcp_pkg.
`timescale 1ns / 1ps

module dgcp_outreg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  dgcp_pkg::rsp_type  res,
   input  logic               rsp_stall,
   output logic               free,
   output logic               rsp_valid,
   output dgcp_pkg::rsp_type  rsp
);

   logic              valid_ff, valid_in;
   dgcp_pkg::rsp_type data_ff;

   assign free      = ~valid_ff | ~rsp_stall;
   assign valid_in  = load | (valid_ff & rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

endmodule

### tb/dgcp_frame_checker.sv
// Frame checker for the decimal gain command parser: tracks accepted bytes, predicts
// each stop or frame result and compares it with the result channel. Uses dgcp_pkg.
`timescale 1ns / 1ps

module dgcp_frame_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [dgcp_pkg::ByteW-1:0]    req_rx_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_kind,
   input  logic                          rsp_run_mode,
   input  logic [dgcp_pkg::ParamW-1:0]   rsp_gain_p,
   input  logic [dgcp_pkg::ParamW-1:0]   rsp_gain_i,
   input  logic [dgcp_pkg::ParamW-1:0]   rsp_gain_d,
   input  logic [dgcp_pkg::ParamW-1:0]   rsp_reference,
   input  logic                          rsp_bad_digit,
   output int                            fail_count,
   output int                            results_owed
);

   import dgcp_pkg::*;

   logic [PosW-1:0]   frame_pos;
   logic [ByteW-1:0]  cmd_byte;
   logic [ParamW-1:0] accum;
   logic [ParamW-1:0] held [NumFields-1];
   logic [ParamW-1:0] params [NumFields];
   logic              saw_bad;
   logic              running;

   rsp_type expected_results [$];
   rsp_type predicted;
   rsp_type oldest;
   logic    produced;
   int      errors = 0;

   assign fail_count = errors;

   function automatic rsp_type current_result(input logic kind, input logic bad);
      rsp_type r;
      r.kind      = kind;
      r.run_mode  = running;
      r.gain_p    = params[0];
      r.gain_i    = params[1];
      r.gain_d    = params[2];
      r.reference = params[3];
      r.bad_digit = bad;
      return r;
   endfunction

   task automatic parse_rx_byte(input logic [ByteW-1:0] b, output logic hit,
                                output rsp_type r);
      logic [DvW-1:0] digit_val;
      int             rel;
      hit = 1'b0;
      r   = '0;
      if (frame_pos == 0 || frame_pos >= FrameLen) begin
         frame_pos = '0;
         if (b == CharStop) begin
            running = 1'b0;
            hit     = 1'b1;
            r       = current_result(KindStop, 1'b0);
         end else begin
            cmd_byte  = b;
            accum     = '0;
            saw_bad   = 1'b0;
            frame_pos = PosW'(1);
         end
      end else begin
         rel = int'(frame_pos) - 1;
         if (b >= CharZero && b <= CharNine) begin
            digit_val = DvW'(b - CharZero);
         end else begin
            digit_val = '0;
            saw_bad   = 1'b1;
         end
         if (rel % DigitsPerField == 0) accum = '0;
         accum     = ParamW'(accum * 10 + digit_val);
         frame_pos = frame_pos + 1'b1;
         if (rel % DigitsPerField == DigitsPerField - 1) begin
            if (rel / DigitsPerField < NumFields - 1) begin
               held[FieldW'(rel / DigitsPerField)] = accum;
            end else begin
               if (cmd_byte == CharRun) running = 1'b1;
               if (!saw_bad) begin
                  params[0] = held[0];
                  params[1] = held[1];
                  params[2] = held[2];
                  params[3] = accum;
               end
               hit       = 1'b1;
               r         = current_result(KindFrame, saw_bad);
               frame_pos = '0;
               accum     = '0;
               saw_bad   = 1'b0;
            end
         end
      end
   endtask

   function automatic int field_differs(input string name, input int unsigned want,
                                        input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         frame_pos = '0;
         cmd_byte  = '0;
         accum     = '0;
         saw_bad   = 1'b0;
         running   = 1'b0;
         for (int i = 0; i < NumFields; i++) params[i] = '0;
         for (int i = 0; i < NumFields - 1; i++) held[i] = '0;
         expected_results.delete();
         results_owed <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_rx_byte(req_rx_byte, produced, predicted);
            if (produced) expected_results.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual kind %0d bad_digit %0d",
                        $time, rsp_kind, rsp_bad_digit);
               errors++;
            end else begin
               oldest = expected_results.pop_front();
               errors += field_differs("kind", 32'(oldest.kind), 32'(rsp_kind));
               errors += field_differs("run_mode", 32'(oldest.run_mode), 32'(rsp_run_mode));
               errors += field_differs("gain_p", 32'(oldest.gain_p), 32'(rsp_gain_p));
               errors += field_differs("gain_i", 32'(oldest.gain_i), 32'(rsp_gain_i));
               errors += field_differs("gain_d", 32'(oldest.gain_d), 32'(rsp_gain_d));
               errors += field_differs("reference", 32'(oldest.reference),
                                       32'(rsp_reference));
               errors += field_differs("bad_digit", 32'(oldest.bad_digit),
                                       32'(rsp_bad_digit));
            end
         end
         results_owed <= expected_results.size();
      end
   end

endmodule

### tb/decimal_gain_command_parser_test.sv
// Testbench top for the decimal gain command parser: clock, reset, byte stream and
// result-side stalls, watchdog and verdict. Depends on dgcp_pkg, the block and dgcp_frame_checker.
`timescale 1ns / 1ps

module decimal_gain_command_parser_test;

   import dgcp_pkg::*;

   localparam int ItemTarget    = 1800;
   localparam int QuietAfter    = 1600;
   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles   = 8;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [ByteW-1:0]    req_rx_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_kind;
   logic                rsp_run_mode;
   logic [ParamW-1:0]   rsp_gain_p;
   logic [ParamW-1:0]   rsp_gain_i;
   logic [ParamW-1:0]   rsp_gain_d;
   logic [ParamW-1:0]   rsp_reference;
   logic                rsp_bad_digit;

   int   fail_count;
   int   results_owed;
   int   idle_cycles = 0;
   int   bytes_sent  = 0;
   int   line_pos    = 0;
   int   gap_odds    = 0;
   logic quiet       = 1'b0;

   always #4 clock = ~clock;

   decimal_gain_command_parser u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_run_mode  (rsp_run_mode),
      .rsp_gain_p    (rsp_gain_p),
      .rsp_gain_i    (rsp_gain_i),
      .rsp_gain_d    (rsp_gain_d),
      .rsp_reference (rsp_reference),
      .rsp_bad_digit (rsp_bad_digit)
   );

   dgcp_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_run_mode  (rsp_run_mode),
      .rsp_gain_p    (rsp_gain_p),
      .rsp_gain_i    (rsp_gain_i),
      .rsp_gain_d    (rsp_gain_d),
      .rsp_reference (rsp_reference),
      .rsp_bad_digit (rsp_bad_digit),
      .fail_count    (fail_count),
      .results_owed  (results_owed)
   );

   task automatic send_byte(input logic [ByteW-1:0] b);
      if (!quiet && gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!(line_pos == 0 && b == CharStop)) line_pos = (line_pos + 1) % FrameLen;
      bytes_sent++;
      if (bytes_sent >= QuietAfter) quiet = 1'b1;
   endtask

   task automatic send_field(input int value);
      for (int d = 1000; d > 0; d /= 10) send_byte(ByteW'(CharZero + (value / d) % 10));
   endtask

   function automatic logic [ByteW-1:0] pick_digit(input int bad_pct);
      if ($urandom_range(0, 99) < bad_pct) begin
         case ($urandom_range(0, 5))
            0:       return CharZero - 1'b1;
            1:       return CharNine + 1'b1;
            2:       return CharStop;
            3:       return '0;
            4:       return '1;
            default: return ByteW'($urandom_range(0, 255));
         endcase
      end
      case ($urandom_range(0, 4))
         0:       return CharZero;
         1:       return CharNine;
         default: return ByteW'(CharZero + $urandom_range(0, 9));
      endcase
   endfunction

   task automatic send_frame(input logic [ByteW-1:0] cmd, input int bad_pct);
      send_byte(cmd);
      repeat (NumFields * DigitsPerField) send_byte(pick_digit(bad_pct));
   endtask

   initial begin
      forever begin
         if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(60, 240)
                                               : $urandom_range(1, 30)) @(posedge clock);
            if (!quiet) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 13)) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_byte(CharStop);
      send_byte(CharRun);
      send_field(9999);
      send_field(0);
      send_field(9999);
      send_field(1234);
      send_byte(CharStop);

      while (bytes_sent < ItemTarget) begin
         if ($urandom_range(0, 19) == 0) begin
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         end
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 16)) send_byte(ByteW'($urandom_range(0, 255)));
         end else begin
            while (line_pos != 0) send_byte(ByteW'($urandom_range(0, 255)));
            if (pick < 22) begin
               send_byte(CharStop);
            end else begin
               send_frame($urandom_range(0, 1) ? CharRun : ByteW'($urandom_range(0, 255)),
                          $urandom_range(0, 9) < 7 ? 0 : $urandom_range(3, 30));
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### files.f
rtl/dgcp_pkg.sv
rtl/dgcp_parse.sv
rtl/dgcp_outreg.sv
rtl/decimal_gain_command_parser.sv
tb/dgcp_frame_checker.sv
tb/decimal_gain_command_parser_test.sv
